[rtl/core/frs_pkg.sv]
// Shared constants for the flag run segmenter.
package frs_pkg;

   localparam int POS_WIDTH_DEF = 20;         // default position width
   localparam int LVL_WIDTH     = 10;         // level register / remainder counter width
   localparam logic [LVL_WIDTH-1:0] LVL_RESET = 10'd1;
   localparam int NUM_CAND      = 4;          // segment candidates per beat
   localparam int MAX_RESULTS   = 3;          // segments one beat can produce
   localparam int IDX_WIDTH     = 2;          // index into result slots
   localparam int CNT_WIDTH     = 2;          // count of filled result slots

endpackage

[rtl/core/frs_if.sv]
// Valid/ready channel interfaces for the request and response sides.
interface frs_req_if;
   logic valid;
   logic ready;
   logic is_new;
   logic stream_end;

   modport source (output valid, output is_new, output stream_end, input ready);
   modport sink   (input valid, input is_new, input stream_end, output ready);
endinterface

interface frs_rsp_if #(
   parameter int POS_WIDTH = frs_pkg::POS_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic                 seg_flag;
   logic [POS_WIDTH-1:0] seg_start;
   logic [POS_WIDTH-1:0] seg_end;
   logic                 final_of_item;
   logic                 final_of_stream;

   modport source (output valid, output seg_flag, output seg_start, output seg_end,
                   output final_of_item, output final_of_stream, input ready);
   modport sink   (input valid, input seg_flag, input seg_start, input seg_end,
                   input final_of_item, input final_of_stream, output ready);
endinterface

[rtl/core/flag_run_segmenter.sv]
// Top level of the flag run segmenter: run state, result slots and response drain.
// Latency: segments of a beat accepted at edge t are offered from the cycle after t.
// Result slots: a beat fills 0..3 of them, drained through the single response port at one
//   segment per cycle while its ready is high; a new beat is taken as the last slot leaves.
// Reset (synchronous, active high): level returns to 1, stream state to its start
//   (position 0, initial zero segment held), result slots empty.
module flag_run_segmenter #(
   parameter int POS_WIDTH = frs_pkg::POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   frs_req_if.sink                       req_bus,
   frs_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [frs_pkg::LVL_WIDTH-1:0] csr_wdata
);
   import frs_pkg::*;

   // level register
   logic [LVL_WIDTH-1:0] level_ff;

   // stream state
   logic [POS_WIDTH-1:0] position_ff,   position_in;
   logic [POS_WIDTH-1:0] run_start_ff,  run_start_in;
   logic                 run_flag_ff,   run_flag_in;
   logic [LVL_WIDTH-1:0] run_rem_ff,    run_rem_in;
   logic [POS_WIDTH-1:0] pend_start_ff, pend_start_in;
   logic [POS_WIDTH-1:0] pend_end_ff,   pend_end_in;
   logic                 pend_valid_ff, pend_valid_in;

   // segment candidates of the current request beat
   logic                 cand_vld   [NUM_CAND];
   logic                 cand_flag  [NUM_CAND];
   logic [POS_WIDTH-1:0] cand_start [NUM_CAND];
   logic [POS_WIDTH-1:0] cand_end   [NUM_CAND];

   // result slots, filled in order, drained from hd_ff up to cnt_ff
   logic                 slot_flag_ff  [MAX_RESULTS];
   logic [POS_WIDTH-1:0] slot_start_ff [MAX_RESULTS];
   logic [POS_WIDTH-1:0] slot_end_ff   [MAX_RESULTS];
   logic                 slot_flag_in  [MAX_RESULTS];
   logic [POS_WIDTH-1:0] slot_start_in [MAX_RESULTS];
   logic [POS_WIDTH-1:0] slot_end_in   [MAX_RESULTS];
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [IDX_WIDTH-1:0] hd_ff, hd_in;
   logic                 last_ff, last_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 slots_empty;
   logic                 on_last_slot;
   logic [CNT_WIDTH-1:0] fill;

   frs_step #(
      .POS_WIDTH (POS_WIDTH)
   ) u_step (
      .is_new        (req_bus.is_new),
      .stream_end    (req_bus.stream_end),
      .level         (level_ff),
      .position      (position_ff),
      .run_start     (run_start_ff),
      .run_flag      (run_flag_ff),
      .run_rem       (run_rem_ff),
      .pend_start    (pend_start_ff),
      .pend_end      (pend_end_ff),
      .pend_valid    (pend_valid_ff),
      .position_nx   (position_in),
      .run_start_nx  (run_start_in),
      .run_flag_nx   (run_flag_in),
      .run_rem_nx    (run_rem_in),
      .pend_start_nx (pend_start_in),
      .pend_end_nx   (pend_end_in),
      .pend_valid_nx (pend_valid_in),
      .cand_vld      (cand_vld),
      .cand_flag     (cand_flag),
      .cand_start    (cand_start),
      .cand_end      (cand_end)
   );

   // handshake: take a new beat when the slots are empty or their last
   // segment leaves in this cycle
   assign slots_empty   = (hd_ff == IDX_WIDTH'(cnt_ff));
   assign on_last_slot  = (CNT_WIDTH'(hd_ff + IDX_WIDTH'(1)) == cnt_ff);
   assign rsp_bus.valid = !slots_empty;
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = slots_empty || (on_last_slot && rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // response payload from the head slot
   assign rsp_bus.seg_flag        = slot_flag_ff[hd_ff];
   assign rsp_bus.seg_start       = slot_start_ff[hd_ff];
   assign rsp_bus.seg_end         = slot_end_ff[hd_ff];
   assign rsp_bus.final_of_item   = on_last_slot;
   assign rsp_bus.final_of_stream = on_last_slot && last_ff;

   // pack valid candidates into consecutive slots (at most three are valid)
   always_comb begin
      fill = '0;
      for (int s = 0; s < MAX_RESULTS; s++) begin
         slot_flag_in[s]  = slot_flag_ff[s];
         slot_start_in[s] = slot_start_ff[s];
         slot_end_in[s]   = slot_end_ff[s];
      end
      for (int j = 0; j < NUM_CAND; j++) begin
         if (cand_vld[j] && (fill < CNT_WIDTH'(MAX_RESULTS))) begin
            slot_flag_in[fill[IDX_WIDTH-1:0]]  = cand_flag[j];
            slot_start_in[fill[IDX_WIDTH-1:0]] = cand_start[j];
            slot_end_in[fill[IDX_WIDTH-1:0]]   = cand_end[j];
            fill = fill + CNT_WIDTH'(1);
         end
      end
   end

   // slot bookkeeping: a loaded beat replaces the drained one
   always_comb begin
      cnt_in  = cnt_ff;
      hd_in   = hd_ff;
      last_in = last_ff;
      if (rsp_fire) begin
         hd_in = hd_ff + IDX_WIDTH'(1);
      end
      if (req_fire) begin
         cnt_in  = fill;
         hd_in   = '0;
         last_in = req_bus.stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= LVL_RESET;
         position_ff   <= '0;
         run_start_ff  <= '0;
         run_flag_ff   <= 1'b0;
         run_rem_ff    <= '0;
         pend_start_ff <= '0;
         pend_end_ff   <= '0;
         pend_valid_ff <= 1'b1;
         cnt_ff        <= '0;
         hd_ff         <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            level_ff <= csr_wdata;
         end
         if (req_fire) begin
            position_ff   <= position_in;
            run_start_ff  <= run_start_in;
            run_flag_ff   <= run_flag_in;
            run_rem_ff    <= run_rem_in;
            pend_start_ff <= pend_start_in;
            pend_end_ff   <= pend_end_in;
            pend_valid_ff <= pend_valid_in;
         end
         cnt_ff  <= cnt_in;
         hd_ff   <= hd_in;
         last_ff <= last_in;
      end
   end

   // slot payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int s = 0; s < MAX_RESULTS; s++) begin
            slot_flag_ff[s]  <= slot_flag_in[s];
            slot_start_ff[s] <= slot_start_in[s];
            slot_end_ff[s]   <= slot_end_in[s];
         end
      end
   end

endmodule

[rtl/core/frs_step.sv]
// Per-beat segmentation logic: next run state and up to four segment candidates.
module frs_step #(
   parameter int POS_WIDTH = frs_pkg::POS_WIDTH_DEF
) (
   input  logic                          is_new,
   input  logic                          stream_end,
   input  logic [frs_pkg::LVL_WIDTH-1:0] level,
   input  logic [POS_WIDTH-1:0]          position,
   input  logic [POS_WIDTH-1:0]          run_start,
   input  logic                          run_flag,
   input  logic [frs_pkg::LVL_WIDTH-1:0] run_rem,
   input  logic [POS_WIDTH-1:0]          pend_start,
   input  logic [POS_WIDTH-1:0]          pend_end,
   input  logic                          pend_valid,
   output logic [POS_WIDTH-1:0]          position_nx,
   output logic [POS_WIDTH-1:0]          run_start_nx,
   output logic                          run_flag_nx,
   output logic [frs_pkg::LVL_WIDTH-1:0] run_rem_nx,
   output logic [POS_WIDTH-1:0]          pend_start_nx,
   output logic [POS_WIDTH-1:0]          pend_end_nx,
   output logic                          pend_valid_nx,
   output logic                          cand_vld   [frs_pkg::NUM_CAND],
   output logic                          cand_flag  [frs_pkg::NUM_CAND],
   output logic [POS_WIDTH-1:0]          cand_start [frs_pkg::NUM_CAND],
   output logic [POS_WIDTH-1:0]          cand_end   [frs_pkg::NUM_CAND]
);
   import frs_pkg::*;

   localparam int SUM_WIDTH = ((POS_WIDTH > LVL_WIDTH) ? POS_WIDTH : LVL_WIDTH) + 1;
   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   logic [SUM_WIDTH-1:0] sum_a;
   logic [SUM_WIDTH-1:0] sum_b;
   logic [POS_WIDTH-1:0] cut_a;
   logic [POS_WIDTH-1:0] cut_b;
   logic [POS_WIDTH-1:0] pos_inc;
   logic [LVL_WIDTH-1:0] rem_inc;

   always_comb begin
      run_flag_nx   = run_flag;
      run_start_nx  = run_start;
      run_rem_nx    = run_rem;
      pend_start_nx = pend_start;
      pend_end_nx   = pend_end;
      pend_valid_nx = pend_valid;
      for (int j = 0; j < NUM_CAND; j++) begin
         cand_vld[j]   = 1'b0;
         cand_flag[j]  = 1'b0;
         cand_start[j] = '0;
         cand_end[j]   = '0;
      end

      // run start at position 0; on a run change, close the run that ends at the current position
      sum_a = SUM_WIDTH'(run_start) + SUM_WIDTH'(run_rem);
      cut_a = (sum_a > SUM_WIDTH'(position)) ? position : sum_a[POS_WIDTH-1:0];
      if (position == '0) begin
         run_flag_nx  = is_new;
         run_start_nx = '0;
         run_rem_nx   = '0;
      end else if (is_new != run_flag) begin
         if (run_flag) begin
            if (pend_valid) begin
               cand_vld[0]   = 1'b1;
               cand_start[0] = pend_start;
               cand_end[0]   = cut_a;
               pend_end_nx   = cut_a;
            end
            pend_valid_nx = 1'b0;
            if (cut_a < position) begin
               cand_vld[1]   = 1'b1;
               cand_flag[1]  = 1'b1;
               cand_start[1] = cut_a;
               cand_end[1]   = position;
            end
         end else begin
            if (pend_valid) begin
               cand_vld[0]   = 1'b1;
               cand_start[0] = pend_start;
               cand_end[0]   = pend_end;
            end
            pend_start_nx = run_start;
            pend_end_nx   = position;
            pend_valid_nx = 1'b1;
         end
         run_start_nx = position;
         run_flag_nx  = is_new;
         run_rem_nx   = '0;
      end

      // remainder counter wraps at level (or at 2^LVL_WIDTH)
      rem_inc    = run_rem_nx + LVL_WIDTH'(1);
      run_rem_nx = (rem_inc == level) ? '0 : rem_inc;

      pos_inc     = (position == POS_MAX) ? POS_MAX : position + POS_WIDTH'(1);
      position_nx = pos_inc;

      // stream end: flush the open run and the held zero segment
      sum_b = SUM_WIDTH'(run_start_nx) + SUM_WIDTH'(run_rem_nx);
      cut_b = (sum_b > SUM_WIDTH'(pos_inc)) ? pos_inc : sum_b[POS_WIDTH-1:0];
      if (stream_end) begin
         if (run_flag_nx) begin
            if (pend_valid_nx) begin
               cand_vld[2]   = 1'b1;
               cand_start[2] = pend_start_nx;
               cand_end[2]   = cut_b;
            end
            if (cut_b < pos_inc) begin
               cand_vld[3]   = 1'b1;
               cand_flag[3]  = 1'b1;
               cand_start[3] = cut_b;
               cand_end[3]   = pos_inc;
            end
         end else begin
            if (pend_valid_nx) begin
               cand_vld[2]   = 1'b1;
               cand_start[2] = pend_start_nx;
               cand_end[2]   = pend_end_nx;
            end
            if (run_start_nx < pos_inc) begin
               cand_vld[3]   = 1'b1;
               cand_start[3] = run_start_nx;
               cand_end[3]   = pos_inc;
            end
         end
         position_nx   = '0;
         run_start_nx  = '0;
         run_flag_nx   = 1'b0;
         run_rem_nx    = '0;
         pend_start_nx = '0;
         pend_end_nx   = '0;
         pend_valid_nx = 1'b1;
      end
   end

endmodule

[verif/flag_run_segmenter_checker.sv]
// Scoreboard for the flag run segmenter: predicts segments per request beat and checks responses.
`timescale 1ns / 100ps

module flag_run_segmenter_checker #(
   parameter int POS_WIDTH = frs_pkg::POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   frs_req_if                            req_mon,
   frs_rsp_if                            rsp_mon,
   input  logic                          csr_we,
   input  logic [frs_pkg::LVL_WIDTH-1:0] csr_wdata,
   output int                            fail_count,
   output int                            segs_left,
   output int                            beats_seen,
   output int                            segs_seen
);
   import frs_pkg::*;

   typedef logic [POS_WIDTH-1:0] pos_t;
   typedef logic [LVL_WIDTH-1:0] lvl_t;

   typedef struct packed {
      logic seg_flag;
      pos_t seg_start;
      pos_t seg_end;
      logic item_last;
      logic stream_last;
   } seg_t;

   localparam pos_t POS_TOP = '1;
   localparam int   REPORT_MAX = 10;

   // model copy of the block state
   lvl_t level;
   pos_t position;
   pos_t run_start;
   logic run_flag;
   lvl_t run_count;
   pos_t held_start;
   pos_t held_end;
   logic held_valid;

   seg_t segs_due[$];      // segments predicted, not yet seen on the response side
   seg_t beat_segs[$];     // segments of the beat being predicted
   int   mismatches;
   int   n_beats;
   int   n_segs;

   function automatic void restart_stream();
      position   = '0;
      run_start  = '0;
      run_flag   = 1'b0;
      run_count  = '0;
      held_start = '0;
      held_end   = '0;
      held_valid = 1'b1;
   endfunction

   function automatic void add_seg(logic flag, pos_t s, pos_t e);
      seg_t sg;
      sg.seg_flag    = flag;
      sg.seg_start   = s;
      sg.seg_end     = e;
      sg.item_last   = 1'b0;
      sg.stream_last = 1'b0;
      beat_segs = {beat_segs, sg};
   endfunction

   // Closing a run of set flags: the front remainder goes to the held zero segment.
   function automatic void close_set_run(pos_t e);
      logic [POS_WIDTH:0] cut;
      cut = {1'b0, run_start};
      cut = cut + (POS_WIDTH+1)'(run_count);
      if (cut > {1'b0, e})
         cut = {1'b0, e};
      if (held_valid) begin
         held_end = cut[POS_WIDTH-1:0];
         add_seg(1'b0, held_start, held_end);
      end
      held_valid = 1'b0;
      if (cut[POS_WIDTH-1:0] < e)
         add_seg(1'b1, cut[POS_WIDTH-1:0], e);
   endfunction

   function automatic void segment_beat(logic flag, logic last);
      pos_t i;
      pos_t n;
      lvl_t nxt;
      beat_segs.delete();
      i = position;
      if (i == '0) begin
         run_flag  = flag;
         run_start = '0;
         run_count = '0;
      end else if (flag != run_flag) begin
         if (run_flag) begin
            close_set_run(i);
         end else begin
            if (held_valid)
               add_seg(1'b0, held_start, held_end);
            held_start = run_start;
            held_end   = i;
            held_valid = 1'b1;
         end
         run_start = i;
         run_flag  = flag;
         run_count = '0;
      end

      // wrapping counter; level 0 behaves as 1024
      nxt = run_count + lvl_t'(1);
      run_count = (nxt == level) ? '0 : nxt;

      n = (i != POS_TOP) ? i + pos_t'(1) : POS_TOP;
      position = n;

      if (last) begin
         if (run_flag) begin
            close_set_run(n);
         end else begin
            if (held_valid)
               add_seg(1'b0, held_start, held_end);
            if (run_start < n)
               add_seg(1'b0, run_start, n);
         end
         restart_stream();
      end

      if (beat_segs.size() > 0) begin
         beat_segs[beat_segs.size() - 1].item_last   = 1'b1;
         beat_segs[beat_segs.size() - 1].stream_last = last;
      end
      segs_due = {segs_due, beat_segs};
   endfunction

   always @(posedge clock) begin
      seg_t got;
      seg_t want;
      if (reset) begin
         level = LVL_RESET;
         restart_stream();
         segs_due.delete();
         mismatches = 0;
         n_beats    = 0;
         n_segs     = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.seg_flag    = rsp_mon.seg_flag;
            got.seg_start   = rsp_mon.seg_start;
            got.seg_end     = rsp_mon.seg_end;
            got.item_last   = rsp_mon.final_of_item;
            got.stream_last = rsp_mon.final_of_stream;
            n_segs++;
            if (segs_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected segment flag=%0d start=%0d end=%0d fi=%0d fs=%0d",
                           $time, got.seg_flag, got.seg_start, got.seg_end,
                           got.item_last, got.stream_last);
            end else begin
               want = segs_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("%0t: segment mismatch exp flag=%0d start=%0d end=%0d fi=%0d fs=%0d,",
                              $time, want.seg_flag, want.seg_start, want.seg_end,
                              want.item_last, want.stream_last);
                     $display("   got flag=%0d start=%0d end=%0d fi=%0d fs=%0d",
                              got.seg_flag, got.seg_start, got.seg_end,
                              got.item_last, got.stream_last);
                  end
               end
            end
         end
         if (csr_we)
            level = csr_wdata;
         if (req_mon.valid && req_mon.ready) begin
            n_beats++;
            segment_beat(req_mon.is_new, req_mon.stream_end);
         end
      end
      fail_count <= mismatches;
      segs_left  <= segs_due.size();
      beats_seen <= n_beats;
      segs_seen  <= n_segs;
   end

endmodule

[verif/flag_run_segmenter_tb.sv]
// Top of the flag run segmenter testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module flag_run_segmenter_tb;
   import frs_pkg::*;

   localparam int POS_WIDTH      = POS_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 1000;   // quiet cycles; longer than the long hold-off
   localparam int HOLD_CYCLES    = 60;
   localparam int SETTLE_CYCLES  = 4;      // beats with no segment may still be in flight
   localparam int TAIL_CYCLES    = 8;
   localparam int PHASE_BEATS    = 50;

   typedef logic [LVL_WIDTH-1:0] lvl_t;

   logic clock;
   logic reset;
   logic csr_we;
   lvl_t csr_wdata;

   frs_req_if                          req_bus ();
   frs_rsp_if #(.POS_WIDTH(POS_WIDTH)) rsp_bus ();

   int   fail_count;
   int   segs_left;
   int   beats_seen;
   int   segs_seen;

   int   beats_sent;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_arm;
   int   hold_count;
   int   quiet_cycles;
   lvl_t last_level;

   flag_run_segmenter #(.POS_WIDTH(POS_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   flag_run_segmenter_checker #(.POS_WIDTH(POS_WIDTH)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .segs_left  (segs_left),
      .beats_seen (beats_seen),
      .segs_seen  (segs_seen)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response side: random stalls, plus one long hold-off when armed by the
   // stimulus so the block backs up and stalls its request side.
   initial begin
      hold_count = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_arm) begin
            hold_arm   = 1'b0;
            hold_count = HOLD_CYCLES;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any beat on either side resets the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d segments outstanding",
                  quiet_cycles, segs_left);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One request beat, preceded by random idle cycles. Valid stays high on
   // return; the next call or a drain decides what it does next.
   task automatic send_beat(input logic flag, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.is_new     <= flag;
      req_bus.stream_end <= last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beats_sent++;
   endtask

   // Stop offering, let every predicted segment come out, give any beat
   // without segments time to clear, then change the level.
   task automatic write_level(input lvl_t value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (segs_left != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      last_level = value;
   endtask

   // Mostly well-formed streams: alternating runs of random length, short runs
   // dominate so the remainders hit every value for small levels, with an
   // occasional long run. About one stream in five is flag noise.
   task automatic send_random_streams(input int beat_goal);
      int   stop_at;
      int   runs;
      int   run_len;
      logic flag;
      stop_at = beats_sent + beat_goal;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            run_len = $urandom_range(1, 10);
            for (int k = 0; k < run_len; k++)
               send_beat(1'($urandom_range(0, 1)), k == run_len - 1);
         end else begin
            runs = $urandom_range(1, 5);
            flag = 1'($urandom_range(0, 1));
            for (int r = 0; r < runs; r++) begin
               run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                      : $urandom_range(1, 7);
               for (int k = 0; k < run_len; k++)
                  send_beat(flag, (r == runs - 1) && (k == run_len - 1));
               flag = ~flag;
            end
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.is_new     <= 1'b0;
      req_bus.stream_end <= 1'b0;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      beats_sent    = 0;
      hold_arm      = 1'b0;
      last_level    = LVL_RESET;
      send_idle_pct = 37;
      recv_idle_pct = 48;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed, level at its reset value of 1 (no trimming) ---
      send_beat(1'b0, 1'b1);   // single zero element: initial segment plus one
      send_beat(1'b1, 1'b1);   // single set element: empty initial segment first
      send_beat(1'b0, 1'b0);
      send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b1);

      // top level: every set run shorter than level, so set segments vanish
      write_level(10'd1023);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b1);

      // level lowered mid-run below the counter value: counter runs on and
      // the cut is clamped to the run end
      write_level(10'd6);
      send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      write_level(10'd2);
      send_beat(1'b1, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b1);

      // --- random phases ---
      send_random_streams(PHASE_BEATS);

      write_level(10'd0);      // counter wrap only: acts as 1024
      send_idle_pct = 48;
      recv_idle_pct = 37;
      send_random_streams(PHASE_BEATS);

      write_level(10'd1023);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_arm = 1'b1;         // long response stall while requests keep coming
      send_random_streams(PHASE_BEATS);

      write_level(lvl_t'($urandom_range(1, 9)));
      send_random_streams(PHASE_BEATS);

      // drain and let the pipeline go quiet
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (segs_left != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request beats and %0d segments; levels 1, 1023, 6, 2, 0, %0d,",
               beats_seen, segs_seen, last_level);
      $display("with idling on either side, none, and one long response hold-off.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d segment errors", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/frs_pkg.sv
rtl/core/frs_if.sv
rtl/core/frs_step.sv
rtl/core/flag_run_segmenter.sv
verif/flag_run_segmenter_checker.sv
verif/flag_run_segmenter_tb.sv
